>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is held.
`define SNC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, skipped while reset is held.
`define SNC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/snc_pkg.sv
package snc_pkg;

    localparam int ADDR_W = 24;
    localparam int LEN_W  = 13;
    localparam int CNT_W  = 8;
    localparam int UPC_W  = 5;

    localparam int PAGE_BYTES        = 256;
    localparam int PAGE_BITS         = $clog2(PAGE_BYTES);
    localparam int MAX_FRAME_DATA    = 252;
    localparam int SECTOR_BYTES      = 4096;
    localparam int MAX_REQUEST_BYTES = 4096;
    localparam int MAX_READ_FRAMES   = 17;
    localparam int RDCNT_W           = $clog2(MAX_READ_FRAMES + 1);

    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_RDSR1   = 8'h05;
    localparam logic [7:0] OP_PROGRAM = 8'h02;
    localparam logic [7:0] OP_ERASE4K = 8'h20;
    localparam logic [7:0] OP_READ    = 8'h03;

    typedef enum logic [1:0] {
        K_READ, K_WRITE, K_ERASE, K_STATUS
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE, PH_WRITING, PH_ERASING
    } t_phase;

    typedef enum logic [1:0] {
        RC_FRAME, RC_DONE, RC_REJECT
    } t_rcode;

    typedef enum logic [2:0] {
        OPS_NONE, OPS_WREN, OPS_RDSR, OPS_XFER, OPS_READ
    } t_op_sel;

    typedef enum logic [1:0] {
        LAST_NO, LAST_YES, LAST_READ
    } t_last_sel;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_LOAD_REQ, ACT_LOAD_READ, ACT_READ_STEP, ACT_ADVANCE, ACT_GO_IDLE
    } t_act;

    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_IS_STATUS, C_ACTIVE, C_LEN_ZERO, C_IS_READ,
        C_IDLE, C_BUSY_BIT, C_LEFT_NZ, C_READ_MORE
    } t_cond;

    typedef struct packed {
        logic             emit;
        t_op_sel          op;
        t_rcode           code;
        t_last_sel        last_sel;
        t_act             act;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        logic             fin;
    } t_uword;

    // Program entry points
    localparam logic [UPC_W-1:0] UA_DISPATCH  = 5'd0;
    localparam logic [UPC_W-1:0] UA_LOAD_READ = 5'd5;
    localparam logic [UPC_W-1:0] UA_READ      = 5'd6;
    localparam logic [UPC_W-1:0] UA_REJECT    = 5'd7;
    localparam logic [UPC_W-1:0] UA_DONE      = 5'd8;
    localparam logic [UPC_W-1:0] UA_STATUS    = 5'd9;
    localparam logic [UPC_W-1:0] UA_CHUNK     = 5'd13;
    localparam logic [UPC_W-1:0] UA_POLL      = 5'd15;
    localparam logic [UPC_W-1:0] UA_END       = 5'd16;

    function automatic t_uword uw_make(logic emit, t_op_sel op, t_rcode code,
                                       t_last_sel last_sel, t_act act, t_cond cond,
                                       logic [UPC_W-1:0] target, logic fin);
        t_uword w;
        w.emit     = emit;
        w.op       = op;
        w.code     = code;
        w.last_sel = last_sel;
        w.act      = act;
        w.cond     = cond;
        w.target   = target;
        w.fin      = fin;
        return w;
    endfunction

    // Control store: a taken jump wins, else fin ends the program, else step on.
    function automatic t_uword ucode(logic [UPC_W-1:0] pc);
        t_uword w;
        w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE, C_NEVER, UA_END, 1'b1);
        case (pc)
            5'd0: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                              C_IS_STATUS, UA_STATUS, 1'b0);
            5'd1: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                              C_ACTIVE, UA_REJECT, 1'b0);
            5'd2: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                              C_LEN_ZERO, UA_DONE, 1'b0);
            5'd3: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                              C_IS_READ, UA_LOAD_READ, 1'b0);
            5'd4: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_LOAD_REQ,
                              C_ALWAYS, UA_CHUNK, 1'b0);
            5'd5: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_LOAD_READ,
                              C_NEVER, UA_END, 1'b0);
            5'd6: w = uw_make(1'b1, OPS_READ, RC_FRAME, LAST_READ, ACT_READ_STEP,
                              C_READ_MORE, UA_READ, 1'b1);
            5'd7: w = uw_make(1'b1, OPS_NONE, RC_REJECT, LAST_YES, ACT_NONE,
                              C_NEVER, UA_END, 1'b1);
            5'd8: w = uw_make(1'b1, OPS_NONE, RC_DONE, LAST_YES, ACT_NONE,
                              C_NEVER, UA_END, 1'b1);
            5'd9: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                              C_IDLE, UA_END, 1'b0);
            5'd10: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                               C_BUSY_BIT, UA_POLL, 1'b0);
            5'd11: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                               C_LEFT_NZ, UA_CHUNK, 1'b0);
            5'd12: w = uw_make(1'b1, OPS_NONE, RC_DONE, LAST_YES, ACT_GO_IDLE,
                               C_NEVER, UA_END, 1'b1);
            5'd13: w = uw_make(1'b1, OPS_WREN, RC_FRAME, LAST_NO, ACT_NONE,
                               C_NEVER, UA_END, 1'b0);
            5'd14: w = uw_make(1'b1, OPS_XFER, RC_FRAME, LAST_NO, ACT_ADVANCE,
                               C_NEVER, UA_END, 1'b0);
            5'd15: w = uw_make(1'b1, OPS_RDSR, RC_FRAME, LAST_YES, ACT_NONE,
                               C_NEVER, UA_END, 1'b1);
            5'd16: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                               C_NEVER, UA_END, 1'b1);
            default: w = uw_make(1'b0, OPS_NONE, RC_FRAME, LAST_NO, ACT_NONE,
                                 C_NEVER, UA_END, 1'b1);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/spi_nor_command_sequencer.sv
// SPI NOR command sequencer.
// Slave channel: one beat per request or returned status byte. tuser carries the
// kind (read, write, erase, status); tdata carries address, length and status.
// Master channel: one beat per result, a frame descriptor or a done / rejected
// note; tlast marks the final result caused by an input beat.
// Each input beat runs a short microprogram, one control word per cycle while
// the output is free; steps that emit a result wait for the output register.
// A write or erase request gives three frames, and a read gives one frame per
// chunk, up to 17 for a 4 KiB read. The microprogram holds off new input:
// o_s_tready is high only between programs.
// A status beat that arrives while no write or erase runs gives no result.
// A stalled receiver holds the output register and freezes the program at its
// next emitting step; nothing is dropped.
// Reset (synchronous, active low) returns to idle with no request in flight
// and drops any pending result.
module spi_nor_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // start_address[23:0], byte_length[36:24],
                                    // status_byte[44:37], zero pad
    input  logic [1:0]  i_s_tuser,  // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // opcode[7:0], frame_address[31:8],
                                    // data_count[39:32]
    output logic [2:0]  o_m_tuser,  // expects_status[0], result_code[2:1]
    output logic        o_m_tlast
);

    localparam int AW = snc_pkg::ADDR_W;
    localparam int LW = snc_pkg::LEN_W;
    localparam int CW = snc_pkg::CNT_W;
    localparam int PW = snc_pkg::UPC_W;
    localparam int RW = snc_pkg::RDCNT_W;

    // Sequencer control
    logic               r_run, n_run;
    logic [PW-1:0]      r_upc, n_upc;
    // Latched input beat
    snc_pkg::t_kind     r_kind, n_kind;
    logic [AW-1:0]      r_req_addr, n_req_addr;
    logic [LW-1:0]      r_len, n_len;
    logic               r_busy_bit, n_busy_bit;
    // Datapath state
    snc_pkg::t_phase    r_phase, n_phase;
    logic [AW-1:0]      r_addr, n_addr;
    logic [LW-1:0]      r_left, n_left;
    logic [RW-1:0]      r_rd_cnt, n_rd_cnt;
    // Output register
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_opcode, n_out_opcode;
    logic [AW-1:0]      r_out_addr, n_out_addr;
    logic [CW-1:0]      r_out_count, n_out_count;
    logic               r_out_status, n_out_status;
    snc_pkg::t_rcode    r_out_code, n_out_code;
    logic               r_out_last, n_out_last;

    snc_pkg::t_uword    uw;
    logic               out_free, step_go, cond_hit, read_more, accept;
    logic [LW-1:0]      in_len, rsize, pg_room, wsize, esize;
    logic [7:0]         fr_opcode;
    logic [AW-1:0]      fr_addr;
    logic [CW-1:0]      fr_count;
    logic               fr_status, fr_last;

    assign uw       = snc_pkg::ucode(r_upc);
    assign out_free = !r_out_valid || i_m_tready;
    assign step_go  = r_run && (!uw.emit || out_free);
    assign accept   = i_s_tvalid && !r_run;
    assign in_len   = i_s_tdata[36:24];

    // Chunk sizes from the running address and remaining length
    always_comb begin
        rsize   = (r_left > LW'(snc_pkg::MAX_FRAME_DATA)) ?
                  LW'(snc_pkg::MAX_FRAME_DATA) : r_left;
        pg_room = LW'(snc_pkg::PAGE_BYTES) - LW'(r_addr[snc_pkg::PAGE_BITS-1:0]);
        wsize   = (rsize > pg_room) ? pg_room : rsize;
        esize   = (r_left > LW'(snc_pkg::SECTOR_BYTES)) ?
                  LW'(snc_pkg::SECTOR_BYTES) : r_left;
        read_more = (r_left != rsize) &&
                    (r_rd_cnt != RW'(snc_pkg::MAX_READ_FRAMES - 1));
    end

    always_comb begin
        case (uw.cond)
            snc_pkg::C_NEVER:     cond_hit = 1'b0;
            snc_pkg::C_ALWAYS:    cond_hit = 1'b1;
            snc_pkg::C_IS_STATUS: cond_hit = (r_kind == snc_pkg::K_STATUS);
            snc_pkg::C_ACTIVE:    cond_hit = (r_phase != snc_pkg::PH_IDLE);
            snc_pkg::C_LEN_ZERO:  cond_hit = (r_len == '0);
            snc_pkg::C_IS_READ:   cond_hit = (r_kind == snc_pkg::K_READ);
            snc_pkg::C_IDLE:      cond_hit = (r_phase == snc_pkg::PH_IDLE);
            snc_pkg::C_BUSY_BIT:  cond_hit = r_busy_bit;
            snc_pkg::C_LEFT_NZ:   cond_hit = (r_left != '0);
            snc_pkg::C_READ_MORE: cond_hit = read_more;
            default:              cond_hit = 1'b0;
        endcase
    end

    // Frame fields for the current step
    always_comb begin
        fr_opcode = 8'h00;
        fr_addr   = '0;
        fr_count  = '0;
        fr_status = 1'b0;
        case (uw.op)
            snc_pkg::OPS_WREN: begin
                fr_opcode = snc_pkg::OP_WREN;
            end
            snc_pkg::OPS_RDSR: begin
                fr_opcode = snc_pkg::OP_RDSR1;
                fr_count  = CW'(1);
                fr_status = 1'b1;
            end
            snc_pkg::OPS_XFER: begin
                fr_addr = r_addr;
                if (r_phase == snc_pkg::PH_WRITING) begin
                    fr_opcode = snc_pkg::OP_PROGRAM;
                    fr_count  = wsize[CW-1:0];
                end else begin
                    fr_opcode = snc_pkg::OP_ERASE4K;
                end
            end
            snc_pkg::OPS_READ: begin
                fr_opcode = snc_pkg::OP_READ;
                fr_addr   = r_addr;
                fr_count  = rsize[CW-1:0];
            end
            default: begin
                fr_opcode = 8'h00;
            end
        endcase
        case (uw.last_sel)
            snc_pkg::LAST_NO:   fr_last = 1'b0;
            snc_pkg::LAST_YES:  fr_last = 1'b1;
            snc_pkg::LAST_READ: fr_last = !read_more;
            default:            fr_last = 1'b0;
        endcase
    end

    always_comb begin
        n_run        = r_run;
        n_upc        = r_upc;
        n_kind       = r_kind;
        n_req_addr   = r_req_addr;
        n_len        = r_len;
        n_busy_bit   = r_busy_bit;
        n_phase      = r_phase;
        n_addr       = r_addr;
        n_left       = r_left;
        n_rd_cnt     = r_rd_cnt;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_opcode = r_out_opcode;
        n_out_addr   = r_out_addr;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        n_out_code   = r_out_code;
        n_out_last   = r_out_last;

        // Latch the beat and start the program at dispatch
        if (accept) begin
            n_run      = 1'b1;
            n_upc      = snc_pkg::UA_DISPATCH;
            n_kind     = snc_pkg::t_kind'(i_s_tuser);
            n_req_addr = i_s_tdata[23:0];
            n_len      = (in_len > LW'(snc_pkg::MAX_REQUEST_BYTES)) ?
                         LW'(snc_pkg::MAX_REQUEST_BYTES) : in_len;
            n_busy_bit = i_s_tdata[37];
        end

        if (step_go) begin
            if (cond_hit) begin
                n_upc = uw.target;
            end else if (uw.fin) begin
                n_run = 1'b0;
            end else begin
                n_upc = r_upc + PW'(1);
            end

            case (uw.act)
                snc_pkg::ACT_LOAD_REQ: begin
                    n_phase = (r_kind == snc_pkg::K_WRITE) ?
                              snc_pkg::PH_WRITING : snc_pkg::PH_ERASING;
                    n_addr  = r_req_addr;
                    n_left  = r_len;
                end
                snc_pkg::ACT_LOAD_READ: begin
                    n_addr   = r_req_addr;
                    n_left   = r_len;
                    n_rd_cnt = '0;
                end
                snc_pkg::ACT_READ_STEP: begin
                    n_addr   = r_addr + AW'(rsize);
                    n_left   = r_left - rsize;
                    n_rd_cnt = r_rd_cnt + RW'(1);
                end
                snc_pkg::ACT_ADVANCE: begin
                    if (r_phase == snc_pkg::PH_WRITING) begin
                        n_addr = r_addr + AW'(wsize);
                        n_left = r_left - wsize;
                    end else begin
                        n_addr = r_addr + AW'(snc_pkg::SECTOR_BYTES);
                        n_left = r_left - esize;
                    end
                end
                snc_pkg::ACT_GO_IDLE: begin
                    n_phase = snc_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (uw.emit) begin
                n_out_valid  = 1'b1;
                n_out_opcode = fr_opcode;
                n_out_addr   = fr_addr;
                n_out_count  = fr_count;
                n_out_status = fr_status;
                n_out_code   = uw.code;
                n_out_last   = fr_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_upc       <= '0;
            r_phase     <= snc_pkg::PH_IDLE;
            r_addr      <= '0;
            r_left      <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_run       <= n_run;
            r_upc       <= n_upc;
            r_phase     <= n_phase;
            r_addr      <= n_addr;
            r_left      <= n_left;
            r_rd_cnt    <= n_rd_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_req_addr   <= n_req_addr;
        r_len        <= n_len;
        r_busy_bit   <= n_busy_bit;
        r_out_opcode <= n_out_opcode;
        r_out_addr   <= n_out_addr;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
        r_out_code   <= n_out_code;
        r_out_last   <= n_out_last;
    end

    assign o_s_tready = !r_run;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_count, r_out_addr, r_out_opcode};
    assign o_m_tuser  = {r_out_code, r_out_status};
    assign o_m_tlast  = r_out_last;

endmodule

>>> rtl/snc_checker.sv
`include "assert_macros.svh"

module snc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [47:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    logic out_beat_note;
    logic out_beat_poll;

    // Done and rejected notes carry no frame and always end their input's results
    assign out_beat_note = o_m_tvalid && (o_m_tuser[2:1] != snc_pkg::RC_FRAME);
    // Status read frames always ask for exactly one byte
    assign out_beat_poll = o_m_tvalid && o_m_tuser[0];

    `SNC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
                    o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)
                    && $stable(o_m_tlast))
    `SNC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
                    !o_s_tready)
    `SNC_ASSERT_IMP(a_note_shape, i_clk, i_rst_n, out_beat_note,
                    o_m_tlast && (o_m_tdata == 40'd0) && !o_m_tuser[0]
                    && ((o_m_tuser[2:1] == snc_pkg::RC_DONE)
                    || (o_m_tuser[2:1] == snc_pkg::RC_REJECT)))
    `SNC_ASSERT_IMP(a_poll_shape, i_clk, i_rst_n, out_beat_poll,
                    (o_m_tdata[7:0] == snc_pkg::OP_RDSR1) && (o_m_tdata[39:32] == 8'd1)
                    && (o_m_tuser[2:1] == snc_pkg::RC_FRAME))

endmodule

bind spi_nor_command_sequencer snc_checker u_snc_checker (.*);

>>> tb/tb_spi_nor_command_sequencer.sv
module tb_spi_nor_command_sequencer;
    import snc_pkg::*;

    localparam int       CLK_HALF     = 4;
    localparam int       RAND_ITEMS   = 400;
    localparam int       HOLD_CYCLES  = 300;
    localparam int       DRAIN_CYCLES = 40;
    localparam int       IDLE_PCT     = 26;
    localparam int       MAX_PRINTS   = 20;
    localparam longint   RUN_LIMIT    = 2_000_000;
    localparam logic [7:0] OP_NONE    = 8'h00;

    typedef enum logic [1:0] {
        CHK_MODEL, CHK_ONE, CHK_NONE
    } t_chk;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [23:0] addr;
        logic [7:0]  count;
        logic        poll;
        t_rcode      code;
        logic        last;
    } t_frame;

    typedef struct {
        t_kind       kind;
        logic [23:0] addr;
        logic [12:0] len;
        logic [7:0]  status;
        t_chk        chk;
        t_frame      typed;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // start_address, byte_length, status_byte, zero pad
    logic [1:0]  i_s_tuser;   // kind
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;   // opcode, frame_address, data_count
    logic [2:0]  o_m_tuser;   // expects_status, result_code
    logic        o_m_tlast;

    spi_nor_command_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Sequencer shadow state
    t_phase      seq_phase = PH_IDLE;
    logic [23:0] seq_addr  = '0;
    int          seq_left  = 0;

    t_frame beat_frames[$];
    t_frame pending_frames[$];

    bit calm       = 1'b0;
    bit hold_start = 1'b0;
    int n_errors   = 0;
    int n_useful   = 0;
    int n_ignored  = 0;
    int n_results  = 0;
    int n_rejects  = 0;
    int n_kind[4]  = '{0, 0, 0, 0};

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("run stopped at the time limit with %0d results pending",
                 pending_frames.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_frame mk_frame(logic [7:0] op, logic [23:0] a, logic [7:0] c,
                                        logic poll, t_rcode rc, logic last);
        t_frame f;
        f.opcode = op;
        f.addr   = a;
        f.count  = c;
        f.poll   = poll;
        f.code   = rc;
        f.last   = last;
        return f;
    endfunction

    function automatic t_stim_row mk_row(t_kind k, logic [23:0] a, logic [12:0] n,
                                         logic [7:0] st, t_chk chk, t_frame typed);
        t_stim_row r;
        r.kind   = k;
        r.addr   = a;
        r.len    = n;
        r.status = st;
        r.chk    = chk;
        r.typed  = typed;
        return r;
    endfunction

    // Write enable, then program or erase at the running address, then first poll.
    function automatic void open_chunk();
        int sz;
        int room;
        beat_frames.push_back(mk_frame(OP_WREN, '0, '0, 1'b0, RC_FRAME, 1'b0));
        if (seq_phase == PH_WRITING) begin
            sz   = (seq_left < MAX_FRAME_DATA) ? seq_left : MAX_FRAME_DATA;
            room = PAGE_BYTES - (int'(seq_addr) % PAGE_BYTES);
            if (room < sz) sz = room;
            beat_frames.push_back(mk_frame(OP_PROGRAM, seq_addr, 8'(sz), 1'b0,
                                           RC_FRAME, 1'b0));
            seq_addr = seq_addr + 24'(sz);
            seq_left = seq_left - sz;
        end else begin
            sz = (seq_left < SECTOR_BYTES) ? seq_left : SECTOR_BYTES;
            beat_frames.push_back(mk_frame(OP_ERASE4K, seq_addr, '0, 1'b0,
                                           RC_FRAME, 1'b0));
            seq_addr = seq_addr + 24'(SECTOR_BYTES);
            seq_left = seq_left - sz;
        end
        beat_frames.push_back(mk_frame(OP_RDSR1, '0, 8'd1, 1'b1, RC_FRAME, 1'b0));
    endfunction

    function automatic void frames_for_beat(t_kind k, logic [23:0] a, logic [12:0] n_in,
                                            logic [7:0] st);
        int          n;
        int          rem;
        int          sz;
        logic [23:0] ra;
        t_frame      f;
        beat_frames.delete();
        n = (n_in > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : int'(n_in);
        if (k == K_STATUS) begin
            if (seq_phase == PH_IDLE) return;
            if (st[0]) begin
                beat_frames.push_back(mk_frame(OP_RDSR1, '0, 8'd1, 1'b1, RC_FRAME, 1'b0));
            end else if (seq_left > 0) begin
                open_chunk();
            end else begin
                seq_phase = PH_IDLE;
                beat_frames.push_back(mk_frame(OP_NONE, '0, '0, 1'b0, RC_DONE, 1'b0));
            end
        end else if (seq_phase != PH_IDLE) begin
            beat_frames.push_back(mk_frame(OP_NONE, '0, '0, 1'b0, RC_REJECT, 1'b0));
        end else if (n == 0) begin
            beat_frames.push_back(mk_frame(OP_NONE, '0, '0, 1'b0, RC_DONE, 1'b0));
        end else if (k == K_READ) begin
            ra  = a;
            rem = n;
            while (rem > 0 && beat_frames.size() < MAX_READ_FRAMES) begin
                sz = (rem < MAX_FRAME_DATA) ? rem : MAX_FRAME_DATA;
                beat_frames.push_back(mk_frame(OP_READ, ra, 8'(sz), 1'b0, RC_FRAME, 1'b0));
                ra  = ra + 24'(sz);
                rem = rem - sz;
            end
        end else begin
            seq_phase = (k == K_WRITE) ? PH_WRITING : PH_ERASING;
            seq_addr  = a;
            seq_left  = n;
            open_chunk();
        end
        if (beat_frames.size() > 0) begin
            f      = beat_frames.pop_back();
            f.last = 1'b1;
            beat_frames.push_back(f);
        end
    endfunction

    task automatic report(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_frame();
        t_frame got;
        t_frame want;
        got = mk_frame(o_m_tdata[7:0], o_m_tdata[31:8], o_m_tdata[39:32], o_m_tuser[0],
                       t_rcode'(o_m_tuser[2:1]), o_m_tlast);
        n_results++;
        if (pending_frames.size() == 0) begin
            report($sformatf("unexpected result beat %p", got));
            return;
        end
        want = pending_frames.pop_front();
        if (want.code == RC_REJECT) n_rejects++;
        if (got.opcode !== want.opcode)
            report($sformatf("opcode %h, want %h", got.opcode, want.opcode));
        if (got.addr !== want.addr)
            report($sformatf("frame_address %h, want %h", got.addr, want.addr));
        if (got.count !== want.count)
            report($sformatf("data_count %0d, want %0d", got.count, want.count));
        if (got.poll !== want.poll)
            report($sformatf("expects_status %b, want %b", got.poll, want.poll));
        if (got.code !== want.code)
            report($sformatf("result_code %0d, want %0d", got.code, want.code));
        if (got.last !== want.last)
            report($sformatf("tlast %b, want %b", got.last, want.last));
    endtask

    // Offer one beat, hold it until taken, then queue what it should produce.
    task automatic send_beat(input t_stim_row sr);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, sr.status, sr.len, sr.addr};
        i_s_tuser  <= sr.kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        frames_for_beat(sr.kind, sr.addr, sr.len, sr.status);
        n_kind[int'(sr.kind)]++;
        if (beat_frames.size() == 0) n_ignored++;
        else n_useful++;
        case (sr.chk)
            CHK_MODEL: foreach (beat_frames[j]) pending_frames.push_back(beat_frames[j]);
            CHK_ONE:   pending_frames.push_back(sr.typed);
            default:   ;
        endcase
    endtask

    task automatic drain_pending();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_frames.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [12:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 13'd0;
        if (r < 12) return 13'($urandom_range(MAX_REQUEST_BYTES + 1, 8191));
        if (r < 20) return 13'($urandom_range(3000, MAX_REQUEST_BYTES));
        return 13'($urandom_range(1, 600));
    endfunction

    function automatic logic [23:0] rand_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 24'hFFF000 + 24'($urandom_range(0, 4095));
        if (r < 35) return 24'($urandom) & 24'hFFFF00;
        return 24'($urandom);
    endfunction

    // Output side: check each taken beat, stall at random or for one long hold-off.
    initial begin
        int hold_left;
        hold_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) check_frame();
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int        r;
        int        goal;
        bit        held;
        bit        paused;
        t_frame    done_f;
        t_frame    rej_f;
        t_frame    poll_f;
        t_frame    none_f;
        t_stim_row tab[$];

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= K_READ;
        held   = 1'b0;
        paused = 1'b0;

        done_f = mk_frame(OP_NONE, '0, '0, 1'b0, RC_DONE, 1'b1);
        rej_f  = mk_frame(OP_NONE, '0, '0, 1'b0, RC_REJECT, 1'b1);
        poll_f = mk_frame(OP_RDSR1, '0, 8'd1, 1'b1, RC_FRAME, 1'b1);
        none_f = '0;

        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'hFF, CHK_NONE,  none_f));
        tab.push_back(mk_row(K_READ,   24'hFFFFFF, 13'd0,    8'h00, CHK_ONE,   done_f));
        tab.push_back(mk_row(K_WRITE,  24'h000000, 13'd0,    8'hFF, CHK_ONE,   done_f));
        tab.push_back(mk_row(K_ERASE,  24'hFFFFFF, 13'd0,    8'h00, CHK_ONE,   done_f));
        tab.push_back(mk_row(K_READ,   24'hFFFFFF, 13'd1,    8'h00, CHK_ONE,
                             mk_frame(OP_READ, 24'hFFFFFF, 8'd1, 1'b0, RC_FRAME, 1'b1)));
        // oversized read: seventeen frames, address wraps past the top
        tab.push_back(mk_row(K_READ,   24'hFFFF00, 13'd8191, 8'h00, CHK_MODEL, none_f));
        tab.push_back(mk_row(K_READ,   24'h000000, 13'd252,  8'h00, CHK_ONE,
                             mk_frame(OP_READ, 24'h000000, 8'd252, 1'b0, RC_FRAME, 1'b1)));
        // write ending at the top of the address space, rest wraps to zero
        tab.push_back(mk_row(K_WRITE,  24'hFFFFF0, 13'd40,   8'h00, CHK_MODEL, none_f));
        tab.push_back(mk_row(K_READ,   24'h000000, 13'd5,    8'h00, CHK_ONE,   rej_f));
        tab.push_back(mk_row(K_STATUS, 24'hFFFFFF, 13'd8191, 8'h01, CHK_ONE,   poll_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'hFE, CHK_MODEL, none_f));
        tab.push_back(mk_row(K_ERASE,  24'h000000, 13'd16,   8'h00, CHK_ONE,   rej_f));
        tab.push_back(mk_row(K_WRITE,  24'hFFFFFF, 13'd8191, 8'hFF, CHK_ONE,   rej_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'hFF, CHK_ONE,   poll_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'h00, CHK_ONE,   done_f));
        // unaligned erase with oversized length: one sector at the given address
        tab.push_back(mk_row(K_ERASE,  24'h000123, 13'd8191, 8'h00, CHK_MODEL, none_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'h03, CHK_ONE,   poll_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'h00, CHK_ONE,   done_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'h00, CHK_NONE,  none_f));
        // write starting on the last byte of a page
        tab.push_back(mk_row(K_WRITE,  24'h0000FF, 13'd300,  8'h00, CHK_MODEL, none_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'h00, CHK_MODEL, none_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'h55, CHK_ONE,   poll_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'h00, CHK_MODEL, none_f));
        tab.push_back(mk_row(K_STATUS, 24'h000000, 13'd0,    8'hAA, CHK_MODEL, none_f));
        tab.push_back(mk_row(K_ERASE,  24'hFFFFFF, 13'd1,    8'h00, CHK_ONE,   rej_f));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tab[i]) send_beat(tab[i]);
        drain_pending();

        goal = n_useful + RAND_ITEMS;
        while (n_useful < goal || seq_phase != PH_IDLE) begin
            if (!held && n_useful >= goal - 300) begin
                held       = 1'b1;
                hold_start = 1'b1;
            end
            if (!paused && n_useful >= goal - 200) begin
                paused = 1'b1;
                drain_pending();
            end
            calm = (n_useful >= goal - 150) && (n_useful < goal - 70);

            r = $urandom_range(0, 99);
            if (seq_phase == PH_IDLE) begin
                if (r < 6)
                    send_beat(mk_row(K_STATUS, rand_addr(), rand_len(), 8'($urandom),
                                     CHK_MODEL, none_f));
                else if (r < 36)
                    send_beat(mk_row(K_READ, rand_addr(), rand_len(), 8'($urandom),
                                     CHK_MODEL, none_f));
                else if (r < 70)
                    send_beat(mk_row(K_WRITE, rand_addr(), rand_len(), 8'($urandom),
                                     CHK_MODEL, none_f));
                else
                    send_beat(mk_row(K_ERASE, rand_addr(), rand_len(), 8'($urandom),
                                     CHK_MODEL, none_f));
            end else if (r < 7) begin
                // stray request in the middle of a program or erase
                send_beat(mk_row(t_kind'($urandom_range(0, 2)), rand_addr(), rand_len(),
                                 8'($urandom), CHK_MODEL, none_f));
            end else if (r < 45) begin
                send_beat(mk_row(K_STATUS, rand_addr(), rand_len(), 8'($urandom) | 8'h01,
                                 CHK_MODEL, none_f));
            end else begin
                send_beat(mk_row(K_STATUS, rand_addr(), rand_len(), 8'($urandom) & 8'hFE,
                                 CHK_MODEL, none_f));
            end
        end
        calm = 1'b0;

        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d reads, %0d writes, %0d erases, %0d status beats (%0d ignored)",
                 n_kind[0], n_kind[1], n_kind[2], n_kind[3], n_ignored);
        $display("checked %0d result beats, %0d rejects, through a long output stall",
                 n_results, n_rejects);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/snc_pkg.sv
rtl/spi_nor_command_sequencer.sv
rtl/snc_checker.sv
tb/tb_spi_nor_command_sequencer.sv
